// File: design/page_bitmap_allocator_defines.svh
// Assertion macros shared by the page bitmap allocator checkers.
`ifndef PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define PBA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define PBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/pba_pkg.sv
// Shared types and constants of the page bitmap allocator.
package pba_pkg;

    localparam int PAGES_DEF    = 256;
    localparam int RESERVED_DEF = 80;

    // Bitmap memory row geometry.
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_MARK_USED = 2'd1,
        REQ_MARK_FREE = 2'd2,
        REQ_QUERY = 2'd3
    } req_kind_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Classified request as it sits in the queue between front and back.
    typedef struct packed {
        req_kind_t   kind;
        logic        range_err;
        logic [7:0]  page;
    } cmd_t;

endpackage

// File: design/page_bitmap_allocator.sv
// Top level of the page bitmap allocator: front end, request queue and back end.
//
//  Channel | Direction | Beat contents (lowest bits first)
//  s_      | in        | tdata: req_type[1:0], page[9:2], zero fill to 16 bits
//  m_      | out       | tdata: page_out, status, page_used, used_count, free_count
//
// A mark or query request first leaves the queue while its bitmap row is read; then the
// row is updated and the result loaded. An out-of-range request, or an allocate that
// finds no free page, loads its result as it leaves the queue.
// An allocate reads rows in turn from the lowest row that may still hold a free page,
// passing over every full 32-page row, then updates the first row that has a free page.
// After reset the back end writes the reset image into the bitmap memory, one row
// of 32 pages per cycle, PAGES/32 rows rounded up in all, with s_tready low.
// The front end keeps accepting into its two-entry queue while the back end is busy,
// and a waiting result keeps the next request, of any kind, in the queue until the result is taken.
module page_bitmap_allocator #(
    parameter int PAGES          = pba_pkg::PAGES_DEF,
    parameter int RESERVED_PAGES = pba_pkg::RESERVED_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // req_type[1:0], page[9:2], zeros[15:10]
    input  logic [pba_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // page_out[7:0], status[9:8], page_used[10], used_count[19:11],
    // free_count[28:20], zeros[31:29]
    output logic [pba_pkg::M_TDATA_W-1:0]   m_tdata
);

    // Classified requests move from the front end to the back end through here.
    logic          q_valid;
    pba_pkg::cmd_t q_cmd;
    logic          q_pop;
    logic          init_busy;

    pba_front #(
        .PAGES (PAGES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .init_busy (init_busy),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    // The back end owns the bitmap, the used counter and the result register.
    pba_back #(
        .PAGES          (PAGES),
        .RESERVED_PAGES (RESERVED_PAGES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: design/pba_front.sv
// Front end: accepts request beats, classifies them and buffers them in a two-entry queue.
module pba_front #(
    parameter int PAGES = pba_pkg::PAGES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pba_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            init_busy,
    output logic                            q_valid,
    output pba_pkg::cmd_t                   q_cmd,
    input  logic                            q_pop
);

    pba_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    pba_pkg::cmd_t in_cmd;
    logic          push;

    always_comb begin
        in_cmd.kind      = pba_pkg::req_kind_t'(s_tdata[1:0]);
        in_cmd.page      = s_tdata[9:2];
        // Allocate ignores the page, so it can never be out of range.
        in_cmd.range_err = (in_cmd.kind != pba_pkg::REQ_ALLOC) &&
                           ({24'd0, in_cmd.page} >= 32'(PAGES));
    end

    assign s_tready = (count_reg != 2'd2) && !init_busy;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// File: design/pba_back.sv
// Back end: bitmap memory, request sequencer, counters and result register.
module pba_back #(
    parameter int PAGES          = pba_pkg::PAGES_DEF,
    parameter int RESERVED_PAGES = pba_pkg::RESERVED_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  pba_pkg::cmd_t                   q_cmd,
    output logic                            q_pop,
    output logic                            init_busy,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pba_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int W       = pba_pkg::WORD_W;
    localparam int BW      = pba_pkg::BIT_W;
    localparam int NROWS   = (PAGES + W - 1) / W;
    localparam int ROW_AW  = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int EXT_W   = ROW_AW + BW;
    localparam int CNT_W   = $clog2(PAGES + 1);
    localparam int RES_EFF = (RESERVED_PAGES > PAGES) ? PAGES : RESERVED_PAGES;

    typedef enum logic [2:0] {
        S_INIT = 3'b001,
        S_IDLE = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    logic [W-1:0]      mem [NROWS];
    logic [W-1:0]      rdata_reg;

    state_t            state_reg, state_next;
    logic [ROW_AW-1:0] init_row_reg, init_row_next;
    logic [ROW_AW-1:0] row_reg, row_next;
    logic [ROW_AW-1:0] hint_reg, hint_next;
    logic [BW-1:0]     bit_reg, bit_next;
    pba_pkg::req_kind_t kind_reg, kind_next;
    logic [7:0]        page_reg, page_next;
    logic [CNT_W-1:0]  total_reg, total_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_page_reg, out_page_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic              out_used_reg, out_used_next;
    logic [CNT_W-1:0]  out_total_reg, out_total_next;

    logic [ROW_AW-1:0] rd_addr;
    logic              mem_we;
    logic [ROW_AW-1:0] mem_waddr;
    logic [W-1:0]      mem_wdata;
    logic [W-1:0]      init_word;
    logic [BW-1:0]     free_idx;
    logic [EXT_W-1:0]  q_ext;
    logic              cur_bit;
    logic              out_free;
    logic [CNT_W-1:0]  free_cnt;

    // Reset image of one row; padding bits past the last page read as used.
    always_comb begin
        for (int j = 0; j < W; j++) begin
            init_word[j] = (32'({init_row_reg, BW'(j)}) < 32'(RES_EFF)) ||
                           (32'({init_row_reg, BW'(j)}) >= 32'(PAGES));
        end
    end

    // Lowest clear bit of the row under scan.
    always_comb begin
        free_idx = '0;
        for (int j = W - 1; j >= 0; j--) begin
            if (!rdata_reg[j]) begin
                free_idx = BW'(j);
            end
        end
    end

    assign q_ext     = EXT_W'(q_cmd.page);
    assign cur_bit   = rdata_reg[bit_reg];
    assign out_free  = !out_valid_reg || m_tready;
    assign init_busy = (state_reg == S_INIT);

    always_comb begin
        state_next      = state_reg;
        init_row_next   = init_row_reg;
        row_next        = row_reg;
        hint_next       = hint_reg;
        bit_next        = bit_reg;
        kind_next       = kind_reg;
        page_next       = page_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;
        out_used_next   = out_used_reg;
        out_total_next  = out_total_reg;
        rd_addr         = row_reg;
        mem_we          = 1'b0;
        mem_waddr       = row_reg;
        mem_wdata       = rdata_reg;
        q_pop           = 1'b0;

        case (state_reg)
            S_INIT: begin
                mem_we        = 1'b1;
                mem_waddr     = init_row_reg;
                mem_wdata     = init_word;
                init_row_next = init_row_reg + 1'b1;
                if (init_row_reg == ROW_AW'(NROWS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop     = 1'b1;
                    kind_next = q_cmd.kind;
                    page_next = q_cmd.page;
                    bit_next  = q_ext[BW-1:0];
                    if (q_cmd.range_err) begin
                        out_valid_next  = 1'b1;
                        out_page_next   = q_cmd.page;
                        out_status_next = pba_pkg::ST_RANGE;
                        out_used_next   = 1'b0;
                        out_total_next  = total_reg;
                    end else if (q_cmd.kind == pba_pkg::REQ_ALLOC &&
                                 total_reg == CNT_W'(PAGES)) begin
                        out_valid_next  = 1'b1;
                        out_page_next   = 8'd0;
                        out_status_next = pba_pkg::ST_FAIL;
                        out_used_next   = 1'b1;
                        out_total_next  = total_reg;
                    end else begin
                        row_next   = (q_cmd.kind == pba_pkg::REQ_ALLOC) ?
                                     hint_reg : q_ext[EXT_W-1:BW];
                        rd_addr    = row_next;
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                case (kind_reg)
                    pba_pkg::REQ_ALLOC: begin
                        if (&rdata_reg) begin
                            row_next = row_reg + 1'b1;
                            rd_addr  = row_next;
                        end else begin
                            mem_we          = 1'b1;
                            mem_wdata       = rdata_reg | (W'(1) << free_idx);
                            total_next      = total_reg + 1'b1;
                            hint_next       = row_reg;
                            out_valid_next  = 1'b1;
                            out_page_next   = 8'({row_reg, free_idx});
                            out_status_next = pba_pkg::ST_OK;
                            out_used_next   = 1'b1;
                            out_total_next  = total_next;
                            state_next      = S_IDLE;
                        end
                    end
                    pba_pkg::REQ_MARK_USED: begin
                        if (cur_bit) begin
                            out_status_next = pba_pkg::ST_FAIL;
                        end else begin
                            mem_we          = 1'b1;
                            mem_wdata       = rdata_reg | (W'(1) << bit_reg);
                            total_next      = total_reg + 1'b1;
                            out_status_next = pba_pkg::ST_OK;
                        end
                        out_valid_next = 1'b1;
                        out_page_next  = page_reg;
                        out_used_next  = 1'b1;
                        out_total_next = total_next;
                        state_next     = S_IDLE;
                    end
                    pba_pkg::REQ_MARK_FREE: begin
                        if (!cur_bit) begin
                            out_status_next = pba_pkg::ST_FAIL;
                        end else begin
                            mem_we          = 1'b1;
                            mem_wdata       = rdata_reg & ~(W'(1) << bit_reg);
                            total_next      = total_reg - 1'b1;
                            out_status_next = pba_pkg::ST_OK;
                            if (row_reg < hint_reg) begin
                                hint_next = row_reg;
                            end
                        end
                        out_valid_next = 1'b1;
                        out_page_next  = page_reg;
                        out_used_next  = 1'b0;
                        out_total_next = total_next;
                        state_next     = S_IDLE;
                    end
                    default: begin
                        out_valid_next  = 1'b1;
                        out_page_next   = page_reg;
                        out_status_next = pba_pkg::ST_OK;
                        out_used_next   = cur_bit;
                        out_total_next  = total_reg;
                        state_next      = S_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            init_row_reg  <= '0;
            hint_reg      <= '0;
            total_reg     <= CNT_W'(RES_EFF);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_row_reg  <= init_row_next;
            hint_reg      <= hint_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg        <= row_next;
        bit_reg        <= bit_next;
        kind_reg       <= kind_next;
        page_reg       <= page_next;
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
        out_used_reg   <= out_used_next;
        out_total_reg  <= out_total_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign free_cnt = CNT_W'(PAGES) - out_total_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, 9'(free_cnt), 9'(out_total_reg), out_used_reg,
                       out_status_reg, out_page_reg};

endmodule

// File: design/pba_checker.sv
// Port-level checks of the page bitmap allocator and their binding to the top level.
`include "page_bitmap_allocator_defines.svh"

module pba_checker #(
    parameter int PAGES = pba_pkg::PAGES_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pba_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic [1:0] m_status;
    logic       m_used;
    logic [8:0] m_used_cnt;
    logic [8:0] m_free_cnt;

    assign m_status   = m_tdata[9:8];
    assign m_used     = m_tdata[10];
    assign m_used_cnt = m_tdata[19:11];
    assign m_free_cnt = m_tdata[28:20];

    `PBA_ASSERT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    `PBA_ASSERT(a_status_code, aclk, aresetn, m_tvalid |-> m_status <= pba_pkg::ST_RANGE, "undefined status code")

    `PBA_ASSERT(a_count_sum, aclk, aresetn, m_tvalid |-> (m_used_cnt + m_free_cnt) == 9'(PAGES), "used and free counts do not add up")

    `PBA_ASSERT(a_range_unused, aclk, aresetn, m_tvalid && m_status == pba_pkg::ST_RANGE |-> !m_used, "out-of-range result shows page used")

    `PBA_ASSERT_ALWAYS(a_init_block, aclk, !aresetn |=> !s_tready && !m_tvalid, "beats possible right after reset")

endmodule

bind page_bitmap_allocator pba_checker #(
    .PAGES (PAGES)
) u_pba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb.sv
// Self-checking testbench for the page bitmap allocator: queued stimulus, bitmap predictor, scoreboard.
module tb;

    localparam int NUM_PAGES    = pba_pkg::PAGES_DEF;
    localparam int NUM_RESERVED = pba_pkg::RESERVED_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    // One request as the sender queues it.
    typedef struct {
        pba_pkg::req_kind_t kind;
        logic [7:0]         page;
    } page_request_t;

    // One reply beat, split into its fields.
    typedef struct {
        logic [7:0] page_out;
        logic [1:0] status;
        logic       page_used;
        logic [8:0] used_count;
        logic [8:0] free_count;
    } page_reply_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [pba_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [pba_pkg::M_TDATA_W-1:0] m_tdata;

    page_request_t pending_requests[$];
    page_reply_t   expected_replies[$];
    page_request_t next_request;
    page_reply_t   seen_reply;
    page_reply_t   want_reply;

    // Predicted allocator state.
    logic [NUM_PAGES-1:0] page_map;
    int                   pages_in_use;

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    logic rx_hold_req = 1'b0;
    logic rx_hold_done = 1'b0;
    int rx_hold_left  = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    page_bitmap_allocator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Applies one request to the predicted bitmap and returns the reply it should produce.
    function automatic page_reply_t apply_request(pba_pkg::req_kind_t kind, logic [7:0] pg);
        page_reply_t r;
        int          slot;
        logic        found;
        logic [7:0]  out_page;
        logic [1:0]  st;
        logic        bit_after;
        found     = 1'b0;
        out_page  = pg;
        st        = pba_pkg::ST_OK;
        bit_after = 1'b0;
        if (kind == pba_pkg::REQ_ALLOC) begin
            // Lowest free page wins; a full bitmap reports page 0 as used.
            for (slot = 0; slot < NUM_PAGES && !found; slot++) begin
                if (!page_map[slot]) begin
                    found          = 1'b1;
                    page_map[slot] = 1'b1;
                    pages_in_use++;
                    out_page       = slot[7:0];
                end
            end
            if (!found) begin
                out_page = '0;
                st       = pba_pkg::ST_FAIL;
            end
            bit_after = 1'b1;
        end else if (int'(pg) >= NUM_PAGES) begin
            st = pba_pkg::ST_RANGE;
        end else if (kind == pba_pkg::REQ_MARK_USED) begin
            if (page_map[pg]) begin
                st = pba_pkg::ST_FAIL;
            end else begin
                page_map[pg] = 1'b1;
                pages_in_use++;
            end
            bit_after = 1'b1;
        end else if (kind == pba_pkg::REQ_MARK_FREE) begin
            if (!page_map[pg]) begin
                st = pba_pkg::ST_FAIL;
            end else begin
                page_map[pg] = 1'b0;
                pages_in_use--;
            end
        end else begin
            bit_after = page_map[pg];
        end
        r.page_out   = out_page;
        r.status     = st;
        r.page_used  = bit_after;
        r.used_count = pages_in_use[8:0];
        r.free_count = 9'(NUM_PAGES - pages_in_use);
        return r;
    endfunction

    function automatic void add_request(pba_pkg::req_kind_t kind, int pg);
        page_request_t q;
        q.kind = kind;
        q.page = pg[7:0];
        pending_requests.push_back(q);
    endfunction

    // Random requests with the given weights in percent; the remainder are queries.
    function automatic void add_random_requests(int count, int alloc_w, int used_w, int free_w);
        int roll;
        int n;
        pba_pkg::req_kind_t kind;
        for (n = 0; n < count; n++) begin
            roll = int'($urandom_range(99));
            if (roll < alloc_w)
                kind = pba_pkg::REQ_ALLOC;
            else if (roll < alloc_w + used_w)
                kind = pba_pkg::REQ_MARK_USED;
            else if (roll < alloc_w + used_w + free_w)
                kind = pba_pkg::REQ_MARK_FREE;
            else
                kind = pba_pkg::REQ_QUERY;
            add_request(kind, int'($urandom_range(255)));
        end
    endfunction

    // Sender: takes the next queued request whenever the bus is free, idling at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_requests.size() != 0 && int'($urandom_range(99)) >= tx_idle_pct) begin
                next_request = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, next_request.page, next_request.kind};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_req && !rx_hold_done) begin
            rx_hold_left <= HOLD_CYCLES;
            rx_hold_done <= 1'b1;
            m_tready     <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= int'($urandom_range(99)) >= rx_stall_pct;
        end
    end

    // Monitor: predicts on every accepted request and checks every accepted reply in order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_replies.push_back(
                    apply_request(pba_pkg::req_kind_t'(s_tdata[1:0]), s_tdata[9:2]));
            if (m_tvalid && m_tready) begin
                seen_reply.page_out   = m_tdata[7:0];
                seen_reply.status     = m_tdata[9:8];
                seen_reply.page_used  = m_tdata[10];
                seen_reply.used_count = m_tdata[19:11];
                seen_reply.free_count = m_tdata[28:20];
                if (expected_replies.size() == 0) begin
                    $error("reply beat 0x%h arrived with no request outstanding", m_tdata);
                    error_count++;
                end else begin
                    want_reply = expected_replies.pop_front();
                    if (seen_reply.page_out !== want_reply.page_out) begin
                        $error("page_out: expected %0d, got %0d",
                               want_reply.page_out, seen_reply.page_out);
                        error_count++;
                    end
                    if (seen_reply.status !== want_reply.status) begin
                        $error("status: expected %0d, got %0d",
                               want_reply.status, seen_reply.status);
                        error_count++;
                    end
                    if (seen_reply.page_used !== want_reply.page_used) begin
                        $error("page_used: expected %0d, got %0d",
                               want_reply.page_used, seen_reply.page_used);
                        error_count++;
                    end
                    if (seen_reply.used_count !== want_reply.used_count) begin
                        $error("used_count: expected %0d, got %0d",
                               want_reply.used_count, seen_reply.used_count);
                        error_count++;
                    end
                    if (seen_reply.free_count !== want_reply.free_count) begin
                        $error("free_count: expected %0d, got %0d",
                               want_reply.free_count, seen_reply.free_count);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Blocks until every queued request has been sent and every reply checked.
    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int p;
        // Reset image: the reserved pages at the bottom are in use.
        for (p = 0; p < NUM_PAGES; p++)
            page_map[p] = (p < NUM_RESERVED);
        pages_in_use = (NUM_RESERVED < NUM_PAGES) ? NUM_RESERVED : NUM_PAGES;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reserved boundary, both ends of the page range, marks in the same
        // state, and allocation refilling a page that was just freed.
        add_request(pba_pkg::REQ_QUERY, 0);
        add_request(pba_pkg::REQ_QUERY, NUM_RESERVED - 1);
        add_request(pba_pkg::REQ_QUERY, NUM_RESERVED);
        add_request(pba_pkg::REQ_QUERY, 255);
        add_request(pba_pkg::REQ_ALLOC, 255);
        add_request(pba_pkg::REQ_ALLOC, 0);
        add_request(pba_pkg::REQ_MARK_FREE, NUM_RESERVED);
        add_request(pba_pkg::REQ_ALLOC, 8'hAA);
        add_request(pba_pkg::REQ_MARK_USED, 255);
        add_request(pba_pkg::REQ_MARK_USED, 255);
        add_request(pba_pkg::REQ_QUERY, 255);
        add_request(pba_pkg::REQ_MARK_FREE, 255);
        add_request(pba_pkg::REQ_MARK_FREE, 255);
        add_request(pba_pkg::REQ_MARK_FREE, 0);
        add_request(pba_pkg::REQ_ALLOC, 8'h55);
        add_request(pba_pkg::REQ_MARK_USED, 0);
        add_request(pba_pkg::REQ_MARK_FREE, NUM_RESERVED - 1);
        add_request(pba_pkg::REQ_MARK_FREE, 8'hAA);
        add_request(pba_pkg::REQ_MARK_USED, 8'h55);
        add_request(pba_pkg::REQ_QUERY, 8'h55);
        add_request(pba_pkg::REQ_ALLOC, 0);
        wait_until_drained();

        // Filling, no idling, with one long receiver hold-off up front.
        @(posedge aclk);
        rx_hold_req <= 1'b1;
        add_random_requests(150, 75, 10, 5);
        wait_until_drained();

        // Filling on past full, so allocation runs out of pages; sparse sender.
        @(posedge aclk);
        tx_idle_pct <= 88;
        add_random_requests(150, 75, 10, 5);
        wait_until_drained();

        // Draining with a receiver that mostly stalls.
        @(posedge aclk);
        tx_idle_pct  <= 0;
        rx_stall_pct <= 88;
        add_random_requests(150, 10, 5, 70);
        wait_until_drained();

        // Even mix with light idling on both sides.
        @(posedge aclk);
        tx_idle_pct  <= 17;
        rx_stall_pct <= 17;
        add_random_requests(150, 30, 25, 25);
        wait_until_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/pba_pkg.sv
design/pba_front.sv
design/pba_back.sv
design/page_bitmap_allocator.sv
design/pba_checker.sv
tb/tb.sv
